// File: rtl/core/code_multiplexed_line_sensor_position_unit_defines.svh
// Assertion macros used by the checker file of the line sensor unit.
`ifndef CODE_MULTIPLEXED_LINE_SENSOR_POSITION_UNIT_DEFINES_SVH
`define CODE_MULTIPLEXED_LINE_SENSOR_POSITION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMLSP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cmlsp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CMLSP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cmlsp: next-cycle check failed");

`endif

// File: rtl/core/cmlsp_pkg.sv
package cmlsp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 24;
    localparam int FLOOR_W    = 15;
    localparam int RAW_W      = 24;
    localparam int POS_W      = 32;
    localparam int PHASE_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int RAW_FIELDS = 4;
    localparam int NTAB       = 6;
    localparam int TAB_IDX_W  = 3;

    localparam logic [RAW_W-1:0] RAW_MAX = 24'd8388608;

    // Per-channel calibration, all Q16. Entries past four are unused channels.
    localparam int K_OFF [NTAB] = '{12954, 22737, 22625, 26790, 0, 0};
    localparam int K_RG  [NTAB] = '{506970, 289375, 319255, 324344, 0, 0};
    localparam int K_MX  [NTAB] = '{329325, 763252, 427616, 104766, 0, 0};
    localparam int K_MY  [NTAB] = '{235897, 53746, -121831, -199236, 0, 0};
    localparam int K_AX  [NTAB] = '{-258782, -651185, -369315, -9339, 0, 0};
    localparam int K_AY  [NTAB] = '{-177019, 10512, 48674, 101679, 0, 0};
    localparam int K_VX  [NTAB] = '{-7995, -29006, -10597, -12694, 0, 0};
    localparam int K_VY  [NTAB] = '{-7196, -13920, 14713, 14798, 0, 0};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DETECT_THRESHOLD = 1'b0,
        REG_FLOOR_VALUE      = 1'b1
    } cfg_reg_t;

    // Multiplier operation; it also tells the datapath where the product goes.
    typedef enum logic [3:0] {
        OP_NONE = 4'd0,
        OP_NORM = 4'd1,
        OP_SQ   = 4'd2,
        OP_MX   = 4'd3,
        OP_AX   = 4'd4,
        OP_MY   = 4'd5,
        OP_AY   = 4'd6,
        OP_VXH  = 4'd7,
        OP_VXL  = 4'd8,
        OP_VYH  = 4'd9,
        OP_VYL  = 4'd10
    } mul_op_t;

    typedef struct packed {
        logic    acc_step;
        logic    acc_clear;
        logic    fin_start;
        logic    raw_load;
        mul_op_t mul_op;
        logic    ch_next;
        logic    round_sums;
        logic    load_step;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic last_ch;
    } dp_stat_t;

    // Round to nearest, halves away from zero, dropping 16 fraction bits.
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[63] ? 64'(-v) : 64'(v);
        m   = (mag + 64'd32768) >> 16;
        return v[63] ? $signed(-m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// File: rtl/core/code_multiplexed_line_sensor_position_unit.sv
// Code-multiplexed line sensor demodulator and position estimator.
// Input channel (s_valid/s_ready/s_sample): one ADC word per accepted
// cycle, unsigned Q2.14. Result channel (m_valid/m_ready/m_*): exactly one
// word per input word, carrying the next emitter drive pattern, a frame
// flag and the position, weight sum and raw channel values of the most
// recent complete frame (all zero after reset).
// An ordinary sample gives its result word in the cycle after it is
// accepted, and a new sample can be taken every cycle while the
// receiver keeps taking the words. The sample that closes a 16-sample
// frame runs the frame finish instead: one shared 32x32 multiplier walks
// the channels in turn, followed by a drain, a rounding and a load step.
// No sample is taken during that time.
// Config writes (cfg_we/cfg_index/cfg_data) land on the next edge and are
// meant for idle periods. Reset (aresetn low, synchronous) restores the
// register defaults, clears phase, accumulators and held results.
// A stalled receiver (m_ready low) holds the result word, and s_ready
// stays low until the word is taken.
module code_multiplexed_line_sensor_position_unit
    import cmlsp_pkg::*;
#(
    parameter int CHANNELS  = 4,
    parameter int ACC_WIDTH = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [SAMPLE_W-1:0]     s_sample,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [PHASE_W-1:0]      m_drive_pattern,
    output logic                    m_frame_valid,
    output logic signed [POS_W-1:0] m_pos_x,
    output logic signed [POS_W-1:0] m_pos_y,
    output logic signed [POS_W-1:0] m_weight_sum,
    output logic [RAW_W-1:0]        m_raw_0,
    output logic [RAW_W-1:0]        m_raw_1,
    output logic [RAW_W-1:0]        m_raw_2,
    output logic [RAW_W-1:0]        m_raw_3
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: accepts words, steps the multiplier ops per channel,
    // owns the result valid flag.
    cmlsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Accumulators, thresholding, shared multiplier and result word.
    cmlsp_dp #(
        .CHANNELS  (CHANNELS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_sample        (s_sample),
        .cmd             (cmd),
        .stat            (stat),
        .m_drive_pattern (m_drive_pattern),
        .m_frame_valid   (m_frame_valid),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_weight_sum    (m_weight_sum),
        .m_raw_0         (m_raw_0),
        .m_raw_1         (m_raw_1),
        .m_raw_2         (m_raw_2),
        .m_raw_3         (m_raw_3)
    );

endmodule

// File: rtl/core/cmlsp_ctrl.sv
module cmlsp_ctrl
    import cmlsp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [15:0] {
        ST_IDLE  = 16'b0000_0000_0000_0001,
        ST_RAW   = 16'b0000_0000_0000_0010,
        ST_NMUL  = 16'b0000_0000_0000_0100,
        ST_NWAIT = 16'b0000_0000_0000_1000,
        ST_SQMUL = 16'b0000_0000_0001_0000,
        ST_MX    = 16'b0000_0000_0010_0000,
        ST_AX    = 16'b0000_0000_0100_0000,
        ST_MY    = 16'b0000_0000_1000_0000,
        ST_AY    = 16'b0000_0001_0000_0000,
        ST_VXH   = 16'b0000_0010_0000_0000,
        ST_VXL   = 16'b0000_0100_0000_0000,
        ST_VYH   = 16'b0000_1000_0000_0000,
        ST_VYL   = 16'b0001_0000_0000_0000,
        ST_DRAIN = 16'b0010_0000_0000_0000,
        ST_RND   = 16'b0100_0000_0000_0000,
        ST_DONE  = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.mul_op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.acc_step = 1'b1;
                    if (stat.frame_end) begin
                        cmd.fin_start = 1'b1;
                        state_next    = ST_RAW;
                    end else begin
                        cmd.load_step = 1'b1;
                        m_valid_next  = 1'b1;
                    end
                end
            end
            ST_RAW: begin
                cmd.raw_load = 1'b1;
                state_next   = ST_NMUL;
            end
            ST_NMUL: begin
                cmd.mul_op = OP_NORM;
                state_next = ST_NWAIT;
            end
            ST_NWAIT: state_next = ST_SQMUL;
            ST_SQMUL: begin
                cmd.mul_op = OP_SQ;
                state_next = ST_MX;
            end
            ST_MX: begin
                cmd.mul_op = OP_MX;
                state_next = ST_AX;
            end
            ST_AX: begin
                cmd.mul_op = OP_AX;
                state_next = ST_MY;
            end
            ST_MY: begin
                cmd.mul_op = OP_MY;
                state_next = ST_AY;
            end
            ST_AY: begin
                cmd.mul_op = OP_AY;
                state_next = ST_VXH;
            end
            ST_VXH: begin
                cmd.mul_op = OP_VXH;
                state_next = ST_VXL;
            end
            ST_VXL: begin
                cmd.mul_op = OP_VXL;
                state_next = ST_VYH;
            end
            ST_VYH: begin
                cmd.mul_op = OP_VYH;
                state_next = ST_VYL;
            end
            ST_VYL: begin
                cmd.mul_op = OP_VYL;
                if (stat.last_ch) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.ch_next = 1'b1;
                    state_next  = ST_RAW;
                end
            end
            ST_DRAIN: state_next = ST_RND;
            ST_RND: begin
                cmd.round_sums = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                cmd.load_out  = 1'b1;
                cmd.acc_clear = 1'b1;
                m_valid_next  = 1'b1;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/core/cmlsp_dp.sv
module cmlsp_dp
    import cmlsp_pkg::*;
#(
    parameter int CHANNELS  = 4,
    parameter int ACC_WIDTH = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic [SAMPLE_W-1:0]          s_sample,
    input  dp_cmd_t                      cmd,
    output dp_stat_t                     stat,
    output logic [PHASE_W-1:0]           m_drive_pattern,
    output logic                         m_frame_valid,
    output logic signed [POS_W-1:0]      m_pos_x,
    output logic signed [POS_W-1:0]      m_pos_y,
    output logic signed [POS_W-1:0]      m_weight_sum,
    output logic [RAW_W-1:0]             m_raw_0,
    output logic [RAW_W-1:0]             m_raw_1,
    output logic [RAW_W-1:0]             m_raw_2,
    output logic [RAW_W-1:0]             m_raw_3
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIDE_W = 34;
    localparam int SW_W   = 40;

    // configuration
    logic signed [THR_W-1:0]   thr_reg;
    logic [FLOOR_W-1:0]        floor_reg;

    // demodulation state
    logic [PHASE_W-1:0]        phase_reg;
    logic [ACC_WIDTH-1:0]      acc_reg [CHANNELS];
    logic [5:0]                phase_ext;
    logic [ACC_WIDTH-1:0]      samp_ext;

    // frame finish datapath
    logic [CH_W-1:0]           ch_cnt_reg;
    logic [TAB_IDX_W-1:0]      tab_idx;
    logic [RAW_W-1:0]          raw_reg;
    logic signed [63:0]        prod_reg;
    mul_op_t                   op_d_reg;
    logic signed [31:0]        norm_reg;
    logic [40:0]               sq_reg;
    logic signed [63:0]        sx_reg;
    logic signed [63:0]        sy_reg;
    logic signed [SW_W-1:0]    sw_reg;
    logic signed [31:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic signed [31:0]        mag;
    logic signed [31:0]        d_val;
    logic signed [63:0]        prod_rnd;

    // thresholding
    logic [ACC_WIDTH-1:0]      acc_sel;
    logic signed [WIDE_W-1:0]  a_ext;
    logic signed [WIDE_W-1:0]  thr_ext;
    logic signed [WIDE_W-1:0]  raw_pick;
    logic [RAW_W-1:0]          raw_calc;

    // output word
    logic [PHASE_W-1:0]        out_drive_reg;
    logic                      out_frame_reg;
    logic signed [POS_W-1:0]   out_x_reg;
    logic signed [POS_W-1:0]   out_y_reg;
    logic signed [POS_W-1:0]   out_w_reg;
    logic [RAW_W-1:0]          out_raw_reg [RAW_FIELDS];

    assign stat.frame_end = (phase_reg == {PHASE_W{1'b1}});
    assign stat.last_ch   = (ch_cnt_reg == CH_W'(CHANNELS - 1));

    assign phase_ext = {2'b00, phase_reg};
    assign samp_ext  = {{(ACC_WIDTH - SAMPLE_W){1'b0}}, s_sample};
    assign tab_idx   = TAB_IDX_W'(ch_cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= -24'sd2458;
            floor_reg <= 15'd16;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DETECT_THRESHOLD: thr_reg   <= cfg_data;
                REG_FLOOR_VALUE:      floor_reg <= cfg_data[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    // the fifth and sixth channels see a zero phase bit and always subtract
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (cmd.acc_clear) begin
            for (int i = 0; i < CHANNELS; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (cmd.acc_step) begin
            phase_reg <= phase_reg + 1'b1;
            for (int i = 0; i < CHANNELS; i++) begin
                acc_reg[i] <= phase_ext[i] ? acc_reg[i] + samp_ext : acc_reg[i] - samp_ext;
            end
        end
    end

    // detected channel takes its negated level, others the floor; clamp to raw range
    always_comb begin
        acc_sel  = acc_reg[ch_cnt_reg];
        a_ext    = {{(WIDE_W - ACC_WIDTH){acc_sel[ACC_WIDTH-1]}}, acc_sel};
        thr_ext  = {{(WIDE_W - THR_W){thr_reg[THR_W-1]}}, thr_reg};
        raw_pick = (a_ext < thr_ext) ? -a_ext
                                     : $signed({{(WIDE_W - FLOOR_W){1'b0}}, floor_reg});
        if (raw_pick[WIDE_W-1]) begin
            raw_calc = '0;
        end else if (raw_pick > $signed({{(WIDE_W - RAW_W){1'b0}}, RAW_MAX})) begin
            raw_calc = RAW_MAX;
        end else begin
            raw_calc = raw_pick[RAW_W-1:0];
        end
    end

    assign d_val = $signed({6'b0, raw_reg, 2'b00}) - K_OFF[tab_idx];
    assign mag   = norm_reg[31] ? -norm_reg : norm_reg;

    always_comb begin
        unique case (cmd.mul_op)
            OP_NORM: begin mul_a = d_val;    mul_b = K_RG[tab_idx]; end
            OP_SQ:   begin mul_a = norm_reg; mul_b = norm_reg;      end
            OP_MX:   begin mul_a = norm_reg; mul_b = K_MX[tab_idx]; end
            OP_AX:   begin mul_a = mag;      mul_b = K_AX[tab_idx]; end
            OP_MY:   begin mul_a = norm_reg; mul_b = K_MY[tab_idx]; end
            OP_AY:   begin mul_a = mag;      mul_b = K_AY[tab_idx]; end
            OP_VXH:  begin mul_a = $signed({7'b0, sq_reg[40:16]});  mul_b = K_VX[tab_idx]; end
            OP_VXL:  begin mul_a = $signed({16'b0, sq_reg[15:0]});  mul_b = K_VX[tab_idx]; end
            OP_VYH:  begin mul_a = $signed({7'b0, sq_reg[40:16]});  mul_b = K_VY[tab_idx]; end
            OP_VYL:  begin mul_a = $signed({16'b0, sq_reg[15:0]});  mul_b = K_VY[tab_idx]; end
            default: begin mul_a = '0;       mul_b = '0;            end
        endcase
    end

    // shared multiplier, product registered with the op that owns it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_d_reg <= OP_NONE;
        end else begin
            op_d_reg <= cmd.mul_op;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod_rnd = rnd16(prod_reg);

    always_ff @(posedge aclk) begin
        if (cmd.fin_start) begin
            ch_cnt_reg <= '0;
        end else if (cmd.ch_next) begin
            ch_cnt_reg <= ch_cnt_reg + 1'b1;
        end
        if (cmd.raw_load) begin
            raw_reg <= raw_calc;
        end
    end

    // product sink; sq-high terms carry a weight of 2^16
    always_ff @(posedge aclk) begin
        priority if (cmd.fin_start) begin
            sx_reg <= '0;
            sy_reg <= '0;
            sw_reg <= '0;
        end else if (cmd.round_sums) begin
            sx_reg <= rnd16(sx_reg);
            sy_reg <= rnd16(sy_reg);
        end else begin
            unique case (op_d_reg)
                OP_NORM: norm_reg <= prod_rnd[31:0];
                OP_SQ: begin
                    sq_reg <= prod_rnd[40:0];
                    sw_reg <= sw_reg + {{(SW_W - 32){norm_reg[31]}}, norm_reg};
                end
                OP_MX, OP_AX, OP_VXL: sx_reg <= sx_reg + prod_reg;
                OP_VXH:               sx_reg <= sx_reg + (prod_reg <<< 16);
                OP_MY, OP_AY, OP_VYL: sy_reg <= sy_reg + prod_reg;
                OP_VYH:               sy_reg <= sy_reg + (prod_reg <<< 16);
                default: ;
            endcase
        end
    end

    // output word; position and raw fields double as the held frame results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_drive_reg <= '0;
            out_frame_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_w_reg     <= '0;
            for (int k = 0; k < RAW_FIELDS; k++) begin
                out_raw_reg[k] <= '0;
            end
        end else begin
            if (cmd.load_step) begin
                out_drive_reg <= phase_reg + 1'b1;
                out_frame_reg <= 1'b0;
            end else if (cmd.load_out) begin
                out_drive_reg <= phase_reg;
                out_frame_reg <= 1'b1;
                out_x_reg     <= sat32(sx_reg);
                out_y_reg     <= sat32(sy_reg);
                out_w_reg     <= sat32({{(64 - SW_W){sw_reg[SW_W-1]}}, sw_reg});
            end
            for (int k = 0; k < RAW_FIELDS; k++) begin
                if (cmd.raw_load && (k < CHANNELS) && (32'(ch_cnt_reg) == k)) begin
                    out_raw_reg[k] <= raw_calc;
                end
            end
        end
    end

    assign m_drive_pattern = out_drive_reg;
    assign m_frame_valid   = out_frame_reg;
    assign m_pos_x         = out_x_reg;
    assign m_pos_y         = out_y_reg;
    assign m_weight_sum    = out_w_reg;
    assign m_raw_0         = out_raw_reg[0];
    assign m_raw_1         = out_raw_reg[1];
    assign m_raw_2         = out_raw_reg[2];
    assign m_raw_3         = out_raw_reg[3];

endmodule

// File: rtl/core/cmlsp_checker.sv
`include "code_multiplexed_line_sensor_position_unit_defines.svh"

module cmlsp_checker
    import cmlsp_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [PHASE_W-1:0]      m_drive_pattern,
    input logic                    m_frame_valid,
    input logic signed [POS_W-1:0] m_pos_x,
    input logic [RAW_W-1:0]        m_raw_0
);

    // a closed frame always leaves the phase at zero
    `CMLSP_ASSERT_IMP(a_frame_phase, aclk, aresetn, m_valid && m_frame_valid, m_drive_pattern == '0)

    // no word is taken while an untaken result blocks the output
    `CMLSP_ASSERT_IMP(a_no_overrun, aclk, aresetn, m_valid && !m_ready, !s_ready)

    // a stalled result word keeps its position
    `CMLSP_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pos_x))

    // and its raw channel value
    `CMLSP_ASSERT_NXT(a_hold_raw, aclk, aresetn, m_valid && !m_ready, $stable(m_raw_0))

    // after a word goes in, either its result is up or the frame finish is running
    `CMLSP_ASSERT_NXT(a_progress, aclk, aresetn, s_valid && s_ready, m_valid || !s_ready)

endmodule

bind code_multiplexed_line_sensor_position_unit cmlsp_checker u_cmlsp_checker (.*);

// File: tb/tb_code_multiplexed_line_sensor_position_unit.sv
module tb_code_multiplexed_line_sensor_position_unit;
    import cmlsp_pkg::*;

    // Accumulator width and channel count of the instance under test.
    localparam int     ACC_W       = 24;
    localparam int     NCH         = 4;
    localparam longint RAW_CEIL    = 8388608;
    // Receiver hold-off used to back the block up into its input.
    localparam int     HOLD_CYCLES = 300;
    // Extra wait at the end, longer than a frame-closing word takes.
    localparam int     END_CYCLES  = 60;

    typedef enum int {
        FRAME_LINE,
        FRAME_FULL_SCALE,
        FRAME_NOISE
    } frame_kind_t;

    // One result word as seen on the m_ side.
    typedef struct {
        logic [PHASE_W-1:0]      drive_pattern;
        logic                    frame_valid;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] weight_sum;
        logic [RAW_W-1:0]        raw [RAW_FIELDS];
    } sensor_word_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [SAMPLE_W-1:0]     s_sample;
    logic                    m_valid;
    logic                    m_ready;
    logic [PHASE_W-1:0]      m_drive_pattern;
    logic                    m_frame_valid;
    logic signed [POS_W-1:0] m_pos_x;
    logic signed [POS_W-1:0] m_pos_y;
    logic signed [POS_W-1:0] m_weight_sum;
    logic [RAW_W-1:0]        m_raw_0;
    logic [RAW_W-1:0]        m_raw_1;
    logic [RAW_W-1:0]        m_raw_2;
    logic [RAW_W-1:0]        m_raw_3;

    // Per-channel calibration in Q16: offset, reciprocal gain, then the
    // moment, abs and variance coefficients for x and y.
    longint cal_off   [NCH] = '{12954, 22737, 22625, 26790};
    longint cal_rgain [NCH] = '{506970, 289375, 319255, 324344};
    longint cal_mx    [NCH] = '{329325, 763252, 427616, 104766};
    longint cal_my    [NCH] = '{235897, 53746, -121831, -199236};
    longint cal_ax    [NCH] = '{-258782, -651185, -369315, -9339};
    longint cal_ay    [NCH] = '{-177019, 10512, 48674, 101679};
    longint cal_vx    [NCH] = '{-7995, -29006, -10597, -12694};
    longint cal_vy    [NCH] = '{-7196, -13920, 14713, 14798};

    // Predictor state: a copy of the block's phase, accumulators,
    // registers and the outputs held from the last complete frame.
    logic [PHASE_W-1:0]      pred_phase;
    logic signed [ACC_W-1:0] pred_acc [NCH];
    logic signed [THR_W-1:0] pred_threshold;
    logic [FLOOR_W-1:0]      pred_floor;
    sensor_word_t            held_word;
    sensor_word_t            pending_words [$];

    int err_count;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_off_req;

    code_multiplexed_line_sensor_position_unit #(
        .CHANNELS  (NCH),
        .ACC_WIDTH (ACC_W)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_pattern (m_drive_pattern),
        .m_frame_valid   (m_frame_valid),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_weight_sum    (m_weight_sum),
        .m_raw_0         (m_raw_0),
        .m_raw_1         (m_raw_1),
        .m_raw_2         (m_raw_2),
        .m_raw_3         (m_raw_3)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Drop 16 fraction bits, nearest, halves away from zero.
    function automatic longint q16_round(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + 32768) >>> 16;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [31:0] clip_s32(longint v);
        if (v > longint'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < longint'(32'sh8000_0000)) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // End of frame: threshold each channel, normalize, build the quadratic
    // position sums in Q32, round once, saturate, clear the accumulators.
    function automatic void close_frame();
        longint a;
        longint raw;
        longint norm;
        longint sq;
        longint mag;
        longint sx;
        longint sy;
        longint sw;
        sx = 0;
        sy = 0;
        sw = 0;
        for (int i = 0; i < NCH; i++) begin
            a = pred_acc[i];
            if (a < pred_threshold) begin
                raw = -a;
            end else begin
                raw = longint'(pred_floor);
            end
            // threshold above zero can give a negative raw value
            if (raw < 0) raw = 0;
            if (raw > RAW_CEIL) raw = RAW_CEIL;
            held_word.raw[i] = raw[RAW_W-1:0];
            norm = q16_round((raw * 4 - cal_off[i]) * cal_rgain[i]);
            sq   = q16_round(norm * norm);
            mag  = (norm < 0) ? -norm : norm;
            sx  += norm * cal_mx[i] + mag * cal_ax[i] + sq * cal_vx[i];
            sy  += norm * cal_my[i] + mag * cal_ay[i] + sq * cal_vy[i];
            sw  += norm;
            pred_acc[i] = '0;
        end
        held_word.pos_x      = clip_s32(q16_round(sx));
        held_word.pos_y      = clip_s32(q16_round(sy));
        held_word.weight_sum = clip_s32(sw);
    endfunction

    // One accepted sample: accumulate by phase bit, advance the phase and
    // queue the word the block owes for it.
    function automatic void demod_step(logic [SAMPLE_W-1:0] s);
        sensor_word_t w;
        for (int i = 0; i < NCH; i++) begin
            if (pred_phase[i]) begin
                pred_acc[i] = pred_acc[i] + s;
            end else begin
                pred_acc[i] = pred_acc[i] - s;
            end
        end
        pred_phase = pred_phase + 1'b1;
        if (pred_phase == '0) begin
            close_frame();
        end
        w               = held_word;
        w.drive_pattern = pred_phase;
        w.frame_valid   = (pred_phase == '0);
        pending_words.push_back(w);
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Compare each accepted result word against the oldest expectation.
    always @(posedge aclk) begin : result_check
        sensor_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("result word accepted with no expectation pending");
                err_count++;
            end else begin
                want = pending_words.pop_front();
                check_field("drive_pattern", want.drive_pattern, m_drive_pattern);
                check_field("frame_valid", want.frame_valid, m_frame_valid);
                check_field("pos_x", want.pos_x, m_pos_x);
                check_field("pos_y", want.pos_y, m_pos_y);
                check_field("weight_sum", want.weight_sum, m_weight_sum);
                check_field("raw_0", want.raw[0], m_raw_0);
                check_field("raw_1", want.raw[1], m_raw_1);
                check_field("raw_2", want.raw[2], m_raw_2);
                check_field("raw_3", want.raw[3], m_raw_3);
            end
        end
    end

    // Receiver: random stall bursts, or one long hold-off on request.
    // Exactly one assignment to m_ready per edge.
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                m_ready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one sample word and predict on acceptance. s_valid is left high
    // so a back-to-back word follows without a bubble; anything else that
    // takes time lowers it first (see settle_block).
    task automatic offer_sample(input logic [SAMPLE_W-1:0] v);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        demod_step(v);
    endtask

    // 16 samples shaped by the drive pattern in force for each one.
    // A line frame puts extra signal on the samples where a chosen emitter
    // is off, so that channel's accumulator goes well negative.
    task automatic send_frame(input frame_kind_t kind);
        logic [NCH-1:0] mask;
        int             base;
        int             amp [NCH];
        int             v;
        mask = NCH'($urandom);
        base = $urandom_range(0, 8000);
        for (int i = 0; i < NCH; i++) begin
            amp[i] = $urandom_range(0, 14000);
        end
        for (int k = 0; k < 16; k++) begin
            case (kind)
                FRAME_NOISE: begin
                    v = $urandom_range(0, 65535);
                end
                FRAME_FULL_SCALE: begin
                    v = ((pred_phase & mask) == '0) ? 65535 : 0;
                end
                default: begin
                    v = base + $urandom_range(0, 255);
                    for (int i = 0; i < NCH; i++) begin
                        if (mask[i] && !pred_phase[i]) v += amp[i];
                    end
                end
            endcase
            if (v > 65535) v = 65535;
            offer_sample(v[SAMPLE_W-1:0]);
        end
    endtask

    function automatic frame_kind_t pick_frame_kind();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return FRAME_LINE;
        if (r < 9) return FRAME_FULL_SCALE;
        return FRAME_NOISE;
    endfunction

    // Stop offering, wait for every owed word, then let the block go idle.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DETECT_THRESHOLD: pred_threshold = $signed(val[THR_W-1:0]);
            REG_FLOOR_VALUE:      pred_floor     = val[FLOOR_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_threshold();
        int t;
        if ($urandom_range(0, 3) == 0) begin
            t = -int'($urandom_range(0, 8388608));
        end else begin
            t = -int'($urandom_range(0, 150000));
        end
        return CFG_DATA_W'(t);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers, one frame with sample extremes and bit patterns.
    task automatic run_directed_frame();
        logic [SAMPLE_W-1:0] v;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int k = 0; k < 16; k++) begin
            case (k)
                0:       v = 16'hFFFF;
                1:       v = 16'h8000;
                2:       v = 16'h0001;
                3:       v = 16'h5555;
                4:       v = 16'hAAAA;
                8:       v = 16'hFFFF;
                default: v = 16'h0000;
            endcase
            offer_sample(v);
        end
    endtask

    // Register extremes: nothing detected, zero threshold, threshold above
    // zero (negated accumulators clamp at zero), floor at 0 and at 16384.
    task automatic run_threshold_sweep();
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] flr;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int s = 0; s < 6; s++) begin
            case (s)
                0: begin thr = 24'h800000;         flr = 24'd0;     end
                1: begin thr = 24'h000000;         flr = 24'd16384; end
                2: begin thr = 24'h7FFFFF;         flr = 24'd1;     end
                3: begin thr = 24'(-2458);         flr = 24'd16;    end
                4: begin thr = random_threshold(); flr = 24'($urandom_range(0, 16384)); end
                default: begin
                    thr = 24'(-1);
                    flr = 24'($urandom_range(0, 16384));
                end
            endcase
            write_reg(REG_DETECT_THRESHOLD, thr);
            write_reg(REG_FLOOR_VALUE, flr);
            send_frame(FRAME_LINE);
            send_frame(FRAME_FULL_SCALE);
            send_frame(FRAME_NOISE);
        end
    endtask

    // Long receiver hold while the sender keeps offering: the held word
    // must block s_ready until it drains.
    task automatic run_output_stall();
        tx_idle_on   = 1'b0;
        hold_off_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
            offer_sample(SAMPLE_W'($urandom));
        end
        tx_idle_on = 1'b1;
    endtask

    // Mostly well-formed line frames with random content, some full-scale
    // and noise frames, fillers of one to three samples to shift frame
    // alignment, and register changes now and then.
    task automatic run_mixed_traffic();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int f = 0; f < 14; f++) begin
            if (f % 5 == 4) begin
                write_reg(REG_DETECT_THRESHOLD, random_threshold());
                write_reg(REG_FLOOR_VALUE, 24'($urandom_range(0, 16384)));
            end
            send_frame(pick_frame_kind());
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) offer_sample(SAMPLE_W'($urandom));
            end
        end
    endtask

    // Back-to-back on both sides, no idling.
    task automatic run_steady_tail();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int f = 0; f < 6; f++) begin
            send_frame(pick_frame_kind());
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_DETECT_THRESHOLD;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_sample       = '0;
        err_count      = 0;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        hold_off_req   = 1'b0;
        pred_phase     = '0;
        pred_threshold = -24'sd2458;
        pred_floor     = 15'd16;
        held_word.drive_pattern = '0;
        held_word.frame_valid   = 1'b0;
        held_word.pos_x         = '0;
        held_word.pos_y         = '0;
        held_word.weight_sum    = '0;
        for (int i = 0; i < NCH; i++) begin
            pred_acc[i]      = '0;
            held_word.raw[i] = '0;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed_frame();
        run_threshold_sweep();
        run_output_stall();
        run_mixed_traffic();
        run_steady_tail();

        settle_block();
        repeat (END_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
